@@ hw/rtl/pdda_pkg.sv @@
package pdda_pkg;

  // Field and state widths.
  localparam int unsigned SmpW  = 8;
  localparam int unsigned SumW  = 16;
  localparam int unsigned CntW  = 7;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned CfgIdxW = 4;

  // Clamp limits for the two divisor registers.
  localparam int unsigned MaxSamples   = 64;
  localparam int unsigned MaxScrollDiv = 64;

  // The divisor is at most MaxSamples * MaxScrollDiv.
  localparam int unsigned DivW = $clog2(MaxSamples * MaxScrollDiv + 1);

  // One quotient bit is resolved per divider step.
  localparam int unsigned DivSteps = SumW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Saturation limits of the accumulators and of the 8-bit results.
  localparam logic signed [SumW:0] SumMax = 17'sd32767;
  localparam logic signed [SumW:0] SumMin = -17'sd32768;
  localparam logic signed [SmpW-1:0] OutMax = 8'sd127;
  localparam logic signed [SmpW-1:0] OutMin = -8'sd128;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSampleCount   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegScrollDivider = 4'd1;
  localparam logic [CfgIdxW-1:0] RegScrollMode    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegPrimarySide   = 4'd3;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] SampleCountRst   = 7'd10;
  localparam logic [CfgW-1:0] ScrollDividerRst = 7'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic decide;
    logic step;
    logic finish;
  } pdda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump;
  } pdda_sts_t;

  // Saturate a 17-bit sum to the 16-bit accumulator range.
  function automatic logic signed [SumW-1:0] sat16(input logic signed [SumW:0] v);
    logic signed [SumW-1:0] r;
    if (v > SumMax) begin
      r = SumMax[SumW-1:0];
    end else if (v < SumMin) begin
      r = SumMin[SumW-1:0];
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

  // Force a register value into the range 1 to hi.
  function automatic logic [CfgW-1:0] clamp_cfg(input logic [CfgW-1:0] v,
                                                input logic [CfgW-1:0] hi);
    logic [CfgW-1:0] r;
    if (v == '0) begin
      r = CfgW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/pdda_ctrl.sv @@
module pdda_ctrl import pdda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  input  pdda_sts_t sts_i,
  output pdda_cmd_t cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecide = 2'd1;
  localparam logic [1:0] StDiv    = 2'd2;
  localparam logic [1:0] StFin    = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The output register can load when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencing of one request through accumulate, decide, a divide on a dump, and finish.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StDecide;
        end
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        cnt_d        = '0;
        state_d      = sts_i.dump ? StDiv : StFin;
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + StepW'(1);
        if (cnt_q == StepW'(DivSteps - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid is set by a finished request and cleared when taken.
  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pdda_dp.sv @@
module pdda_dp import pdda_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic signed [SmpW-1:0] sample_x_i,
  input  logic signed [SmpW-1:0] sample_y_i,
  input  pdda_cmd_t              cmd_i,
  output pdda_sts_t              sts_o,
  output logic signed [SmpW-1:0] delta_x_o,
  output logic signed [SmpW-1:0] delta_y_o,
  output logic signed [SmpW-1:0] move_x_o,
  output logic signed [SmpW-1:0] move_y_o,
  output logic signed [SmpW-1:0] scroll_h_o,
  output logic signed [SmpW-1:0] scroll_v_o,
  output logic                   report_changed_o
);

  // Configuration registers.
  logic [CfgW-1:0] sample_count_q, scroll_divider_q;
  logic            scroll_mode_q, primary_side_q;

  // Accumulators and sample counter.
  logic signed [SumW-1:0] sum_x_q, sum_y_q;
  logic [CntW-1:0]        seen_q;

  // Divider lanes: dividend magnitude shifts out of the quotient register into the remainder.
  logic [DivW-1:0] div_q;
  logic [SumW-1:0] quo_x_q, quo_y_q;
  logic [DivW-1:0] rem_x_q, rem_y_q;
  logic            neg_x_q, neg_y_q, dump_q;

  // Output payload registers.
  logic signed [SmpW-1:0] dx_q, dy_q, mx_q, my_q, sh_q, sv_q;
  logic                   chg_q;

  logic [CfgW-1:0]   n_eff, sd_eff;
  logic [2*CfgW-1:0] div_prod;
  logic [SumW-1:0]   mag_x, mag_y;
  logic              mode_clear;

  // Effective divisor and dump decision for the current count.
  assign n_eff    = clamp_cfg(sample_count_q, CfgW'(MaxSamples));
  assign sd_eff   = clamp_cfg(scroll_divider_q, CfgW'(MaxScrollDiv));
  assign div_prod = (scroll_mode_q || !primary_side_q) ? n_eff * sd_eff
                                                       : (2*CfgW)'(n_eff);
  assign sts_o.dump = (seen_q >= n_eff);

  assign mag_x = sum_x_q[SumW-1] ? SumW'(-sum_x_q) : SumW'(sum_x_q);
  assign mag_y = sum_y_q[SumW-1] ? SumW'(-sum_y_q) : SumW'(sum_y_q);

  assign mode_clear = cfg_we_i && (cfg_index_i == RegScrollMode) &&
                      (cfg_data_i[0] != scroll_mode_q);

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q   <= SampleCountRst;
      scroll_divider_q <= ScrollDividerRst;
      scroll_mode_q    <= 1'b0;
      primary_side_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSampleCount:   sample_count_q   <= cfg_data_i;
        RegScrollDivider: scroll_divider_q <= cfg_data_i;
        RegScrollMode:    scroll_mode_q    <= cfg_data_i[0];
        RegPrimarySide:   primary_side_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // One restoring divide step for a lane.
  function automatic logic [DivW+SumW-1:0] div_step(input logic [DivW-1:0] rem,
                                                     input logic [SumW-1:0] quo,
                                                     input logic [DivW-1:0] dvs);
    logic [DivW:0] shifted, trial;
    logic [DivW-1:0] rem_n;
    logic            bit_n;
    shifted = {rem, quo[SumW-1]};
    trial   = shifted - {1'b0, dvs};
    if (!trial[DivW]) begin
      rem_n = trial[DivW-1:0];
      bit_n = 1'b1;
    end else begin
      rem_n = shifted[DivW-1:0];
      bit_n = 1'b0;
    end
    return {rem_n, quo[SumW-2:0], bit_n};
  endfunction

  // Clip a signed quotient, given as sign and magnitude, to 8 bits.
  function automatic logic signed [SmpW-1:0] clip_q(input logic neg,
                                                     input logic [SumW-1:0] mag);
    logic signed [SmpW-1:0] r;
    if (!neg) begin
      r = (mag > SumW'(127)) ? OutMax : SmpW'(mag);
    end else begin
      r = (mag > SumW'(128)) ? OutMin : SmpW'(-mag);
    end
    return r;
  endfunction

  // Accumulators, sample counter and remainder write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      seen_q  <= '0;
    end else if (mode_clear) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      seen_q  <= '0;
    end else if (cmd_i.accept) begin
      sum_x_q <= sat16((SumW+1)'(sum_x_q) + (SumW+1)'(sample_x_i));
      sum_y_q <= sat16((SumW+1)'(sum_y_q) - (SumW+1)'(sample_y_i));
      seen_q  <= seen_q + CntW'(1);
    end else if (cmd_i.finish && dump_q) begin
      sum_x_q <= neg_x_q ? -$signed(SumW'(rem_x_q)) : $signed(SumW'(rem_x_q));
      sum_y_q <= neg_y_q ? -$signed(SumW'(rem_y_q)) : $signed(SumW'(rem_y_q));
      seen_q  <= '0;
    end
  end

  // Shared two-lane divider: loaded at the decision, one bit per step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      dump_q  <= sts_o.dump;
      div_q   <= DivW'(div_prod);
      quo_x_q <= mag_x;
      quo_y_q <= mag_y;
      rem_x_q <= '0;
      rem_y_q <= '0;
      neg_x_q <= sum_x_q[SumW-1];
      neg_y_q <= sum_y_q[SumW-1];
    end else if (cmd_i.step) begin
      {rem_x_q, quo_x_q} <= div_step(rem_x_q, quo_x_q, div_q);
      {rem_y_q, quo_y_q} <= div_step(rem_y_q, quo_y_q, div_q);
    end
  end

  // Result formatting into the output register.
  always_ff @(posedge clk_i) begin
    logic signed [SmpW-1:0] dx, dy, mx, my, sh, sv;
    logic                   nz, chg;
    dx  = '0;
    dy  = '0;
    mx  = '0;
    my  = '0;
    sh  = '0;
    sv  = '0;
    chg = 1'b0;
    if (dump_q) begin
      dx = clip_q(neg_x_q, quo_x_q);
      dy = clip_q(neg_y_q, quo_y_q);
    end
    nz = (dx != '0) || (dy != '0);
    if (primary_side_q && nz) begin
      chg = 1'b1;
      if (scroll_mode_q) begin
        sh = dx;
        sv = (dy == OutMin) ? OutMax : -dy;
      end else begin
        mx = dx;
        my = dy;
      end
    end
    if (cmd_i.finish) begin
      dx_q  <= dx;
      dy_q  <= dy;
      mx_q  <= mx;
      my_q  <= my;
      sh_q  <= sh;
      sv_q  <= sv;
      chg_q <= chg;
    end
  end

  assign delta_x_o        = dx_q;
  assign delta_y_o        = dy_q;
  assign move_x_o         = mx_q;
  assign move_y_o         = my_q;
  assign scroll_h_o       = sh_q;
  assign scroll_v_o       = sv_q;
  assign report_changed_o = chg_q;

endmodule

@@ hw/rtl/pointer_delta_decimating_averager_unit.sv @@
// Averages motion samples from an optical sensor and emits pointer deltas.
// Input channel: in_valid_i/in_stall_o with sample_x_i and sample_y_i.
// One request is accepted when valid is high and stall is low; y is negated
// and both axes add into saturating 16-bit accumulators.
// Output channel: out_valid_o/out_stall_i; exactly one result per request.
// When the sample count reaches sample_count, both sums are divided by the
// divisor, the quotients are clipped to 8 bits and the remainders are kept.
// A result is offered from the output register once the request has passed the
// decide and finish states, and on a dump also the divide state, where the shared
// two-lane restoring divider resolves one quotient bit per cycle.
// One request is in flight at a time, so a new request is accepted only once the
// last one has finished; a finished result waits in the
// output register while the next request is accepted and worked on.
// A stalled receiver holds the result; the next result waits until taken.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i,
// always ready; written only while the block is idle, a rule left to the user.
// Reset clears the accumulators and restores the register defaults.
module pointer_delta_decimating_averager_unit import pdda_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [SmpW-1:0] sample_x_i,
  input  logic signed [SmpW-1:0] sample_y_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [SmpW-1:0] delta_x_o,
  output logic signed [SmpW-1:0] delta_y_o,
  output logic signed [SmpW-1:0] move_x_o,
  output logic signed [SmpW-1:0] move_y_o,
  output logic signed [SmpW-1:0] scroll_h_o,
  output logic signed [SmpW-1:0] scroll_v_o,
  output logic                   report_changed_o
);

  pdda_cmd_t cmd;
  pdda_sts_t sts;

  // Register writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  pdda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pdda_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .sample_x_i       (sample_x_i),
    .sample_y_i       (sample_y_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .delta_x_o        (delta_x_o),
    .delta_y_o        (delta_y_o),
    .move_x_o         (move_x_o),
    .move_y_o         (move_y_o),
    .scroll_h_o       (scroll_h_o),
    .scroll_v_o       (scroll_v_o),
    .report_changed_o (report_changed_o)
  );

endmodule

@@ hw/rtl/pdda_checker.sv @@
module pdda_checker import pdda_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic signed [SmpW-1:0] delta_x_o,
  input logic signed [SmpW-1:0] delta_y_o,
  input logic signed [SmpW-1:0] move_x_o,
  input logic signed [SmpW-1:0] move_y_o,
  input logic signed [SmpW-1:0] scroll_h_o,
  input logic signed [SmpW-1:0] scroll_v_o,
  input logic                   report_changed_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request accepted while busy");

  // A reported change always carries a nonzero delta.
  a_chg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_changed_o |-> (delta_x_o != '0) || (delta_y_o != '0))
    else $error("report without delta");

  // Without a report the move and scroll fields are zero.
  a_no_chg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_changed_o |->
      (move_x_o == '0) && (move_y_o == '0) && (scroll_h_o == '0) && (scroll_v_o == '0))
    else $error("report fields set without a report");

  // Cursor and scroll fields are never filled together.
  a_route_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(((move_x_o != '0) || (move_y_o != '0)) &&
                      ((scroll_h_o != '0) || (scroll_v_o != '0))))
    else $error("delta routed to both cursor and scroll");

endmodule

bind pointer_delta_decimating_averager_unit pdda_checker u_pdda_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .delta_x_o        (delta_x_o),
  .delta_y_o        (delta_y_o),
  .move_x_o         (move_x_o),
  .move_y_o         (move_y_o),
  .scroll_h_o       (scroll_h_o),
  .scroll_v_o       (scroll_v_o),
  .report_changed_o (report_changed_o)
);
